// ----- hw/rtl/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants and types for the 3x3x3 box max/min filter.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd3;

  // filter mode codes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam int DIM_W   = 7;    // columns / rows register width
  localparam int LVL_W   = 12;   // levels register and level index width
  localparam int MIN_DIM = 3;

  localparam logic [DIM_W-1:0] RST_COLS   = 7'd64;
  localparam logic [DIM_W-1:0] RST_ROWS   = 7'd64;
  localparam logic [LVL_W-1:0] RST_LEVELS = 12'd16;

  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_CHANNELS    = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  // flags that ride along with every token between the passes
  typedef struct packed {
    logic last;     // final result of the input sample
    logic at_end;   // result for the very last voxel channel
  } bmm_ctl_t;

endpackage

// ----- hw/rtl/box_max_min_filter_3x3x3_top.sv -----
// ----------------------------------------------------------------------------
// box_max_min_filter_3x3x3_top
// 3x3x3 grayscale dilation/erosion over a raster-ordered volume, built as a
// level pass, a row pass and a column pass, each on its own history RAM.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_ready  in_sample
//   out_     out        out_valid/out_ready result, position, flags
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// One sample per cycle while in_ready is high; each pass emits one token per
// cycle unless stalled, so a sample whose index is last on an axis holds that
// pass while it emits its second token, and the last voxel of a volume gives
// eight results at the result port. Synchronous active-low reset clears
// control state; the history RAMs are never cleared. Backpressure on
// out_ready stalls back through every pass.
// ----------------------------------------------------------------------------
module box_max_min_filter_3x3x3_top
  import bmm_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int COL_W = $clog2(MAX_COLS),
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_result,
  output logic [LVL_W-1:0]              out_level,
  output logic [ROW_W-1:0]              out_row,
  output logic [COL_W-1:0]              out_col,
  output logic [CH_W-1:0]               out_channel,
  output logic                          out_last_of_run,
  output logic                          out_end_of_volume,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int LP_ADDR_W = ROW_W + COL_W + CH_W;
  localparam int RP_ADDR_W = 1 + COL_W + CH_W;
  localparam int RP_TAG_W  = LVL_W + 1 + COL_W + CH_W;
  localparam int CP_ADDR_W = 2 + CH_W;
  localparam int CP_TAG_W  = LVL_W + ROW_W + CH_W;

  logic             mode_r;
  logic [DIM_W-1:0] cols_r;
  logic [DIM_W-1:0] rows_r;
  logic [LVL_W-1:0] levels_r;
  logic [CH_W-1:0]  ch_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [LVL_W-1:0] lvl_r;

  logic [COL_W:0]   col_n;
  logic [ROW_W:0]   row_n;
  logic [LVL_W:0]   lvl_n;
  logic             last_ch;
  logic             last_col;
  logic             last_row;
  logic             last_lvl;
  logic             in_take;
  bmm_ctl_t         in_ctl;

  // level pass -> row pass
  logic                          lv_valid;
  logic                          lv_ready;
  logic signed [SAMPLE_BITS-1:0] lv_val;
  logic [LVL_W-1:0]              lv_idx;
  logic                          lv_slot;
  logic [LP_ADDR_W-1:0]          lv_tag;
  bmm_ctl_t                      lv_ctl;
  logic [ROW_W-1:0]              lv_row;
  logic [COL_W-1:0]              lv_col;
  logic [CH_W-1:0]               lv_ch;

  // row pass -> column pass
  logic                          rv_valid;
  logic                          rv_ready;
  logic signed [SAMPLE_BITS-1:0] rv_val;
  logic [ROW_W-1:0]              rv_idx;
  logic                          rv_slot;
  logic [RP_TAG_W-1:0]           rv_tag;
  bmm_ctl_t                      rv_ctl;
  logic [LVL_W-1:0]              rv_tl;
  logic                          rv_sl;
  logic [COL_W-1:0]              rv_col;
  logic [CH_W-1:0]               rv_ch;

  logic [CP_TAG_W-1:0]           cp_tag;
  bmm_ctl_t                      cp_ctl;

  // dimensions with out-of-range values pulled in
  always_comb begin
    if (cols_r < DIM_W'(MIN_DIM)) begin
      col_n = (COL_W+1)'(MIN_DIM);
    end else if (32'(cols_r) > MAX_COLS) begin
      col_n = (COL_W+1)'(MAX_COLS);
    end else begin
      col_n = (COL_W+1)'(cols_r);
    end
    if (rows_r < DIM_W'(MIN_DIM)) begin
      row_n = (ROW_W+1)'(MIN_DIM);
    end else if (32'(rows_r) > MAX_ROWS) begin
      row_n = (ROW_W+1)'(MAX_ROWS);
    end else begin
      row_n = (ROW_W+1)'(rows_r);
    end
    if (levels_r < LVL_W'(MIN_DIM)) begin
      lvl_n = (LVL_W+1)'(MIN_DIM);
    end else begin
      lvl_n = {1'b0, levels_r};
    end
  end

  assign last_ch  = (ch_r == CH_W'(CHANNELS - 1));
  assign last_col = ({1'b0, col_r} == (col_n - 1'b1));
  assign last_row = ({1'b0, row_r} == (row_n - 1'b1));
  assign last_lvl = ({1'b0, lvl_r} == (lvl_n - 1'b1));
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MAX;
      cols_r   <= RST_COLS;
      rows_r   <= RST_ROWS;
      levels_r <= RST_LEVELS;
      ch_r     <= '0;
      col_r    <= '0;
      row_r    <= '0;
      lvl_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[0];
        CFG_COLS:   cols_r   <= cfg_wdata[DIM_W-1:0];
        CFG_ROWS:   rows_r   <= cfg_wdata[DIM_W-1:0];
        CFG_LEVELS: levels_r <= cfg_wdata;
        default: ;
      endcase
      // new geometry starts a new volume
      if (cfg_index inside {CFG_COLS, CFG_ROWS, CFG_LEVELS}) begin
        ch_r  <= '0;
        col_r <= '0;
        row_r <= '0;
        lvl_r <= '0;
      end
    end else if (in_take) begin
      if (!last_ch) begin
        ch_r <= ch_r + 1'b1;
      end else begin
        ch_r <= '0;
        if (!last_col) begin
          col_r <= col_r + 1'b1;
        end else begin
          col_r <= '0;
          if (!last_row) begin
            row_r <= row_r + 1'b1;
          end else begin
            row_r <= '0;
            lvl_r <= last_lvl ? '0 : lvl_r + 1'b1;
          end
        end
      end
    end
  end

  assign in_ctl = '{last: 1'b1, at_end: last_ch};

  // level pass: history of the two previous levels, per row/column/channel
  bmm_pass #(
    .VAL_W  (SAMPLE_BITS),
    .IDX_W  (LVL_W),
    .ADDR_W (LP_ADDR_W),
    .TAG_W  (LP_ADDR_W)
  ) u_lvl_pass (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .axis_n    (lvl_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_val    (in_sample),
    .in_idx    (lvl_r),
    .in_addr   ({row_r, col_r, ch_r}),
    .in_tag    ({row_r, col_r, ch_r}),
    .in_ctl    (in_ctl),
    .out_valid (lv_valid),
    .out_ready (lv_ready),
    .out_val   (lv_val),
    .out_idx   (lv_idx),
    .out_slot  (lv_slot),
    .out_tag   (lv_tag),
    .out_ctl   (lv_ctl)
  );

  assign {lv_row, lv_col, lv_ch} = lv_tag;

  // row pass: keyed by level target slot, column and channel
  bmm_pass #(
    .VAL_W  (SAMPLE_BITS),
    .IDX_W  (ROW_W),
    .ADDR_W (RP_ADDR_W),
    .TAG_W  (RP_TAG_W)
  ) u_row_pass (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .axis_n    (row_n),
    .in_valid  (lv_valid),
    .in_ready  (lv_ready),
    .in_val    (lv_val),
    .in_idx    (lv_row),
    .in_addr   ({lv_slot, lv_col, lv_ch}),
    .in_tag    ({lv_idx, lv_slot, lv_col, lv_ch}),
    .in_ctl    (lv_ctl),
    .out_valid (rv_valid),
    .out_ready (rv_ready),
    .out_val   (rv_val),
    .out_idx   (rv_idx),
    .out_slot  (rv_slot),
    .out_tag   (rv_tag),
    .out_ctl   (rv_ctl)
  );

  assign {rv_tl, rv_sl, rv_col, rv_ch} = rv_tag;

  // column pass: keyed by level slot, row slot and channel
  bmm_pass #(
    .VAL_W  (SAMPLE_BITS),
    .IDX_W  (COL_W),
    .ADDR_W (CP_ADDR_W),
    .TAG_W  (CP_TAG_W)
  ) u_col_pass (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .axis_n    (col_n),
    .in_valid  (rv_valid),
    .in_ready  (rv_ready),
    .in_val    (rv_val),
    .in_idx    (rv_col),
    .in_addr   ({rv_sl, rv_slot, rv_ch}),
    .in_tag    ({rv_tl, rv_idx, rv_ch}),
    .in_ctl    (rv_ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_val   (out_result),
    .out_idx   (out_col),
    .out_slot  (),
    .out_tag   (cp_tag),
    .out_ctl   (cp_ctl)
  );

  assign {out_level, out_row, out_channel} = cp_tag;
  assign out_last_of_run   = cp_ctl.last;
  assign out_end_of_volume = cp_ctl.at_end;

  // end of volume lands on the last voxel channel and closes its run
  a_eov_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_volume |->
      out_last_of_run && (out_channel == CH_W'(CHANNELS - 1)) &&
      ({1'b0, out_col} == (col_n - 1'b1)) && ({1'b0, out_row} == (row_n - 1'b1)))
    else $error("end_of_volume on a voxel that is not the last one");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_level} < lvl_n) && ({1'b0, out_row} < row_n) &&
                  ({1'b0, out_col} < col_n))
    else $error("result position outside the volume");

  a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < col_n) && ({1'b0, row_r} < row_n) && ({1'b0, lvl_r} < lvl_n))
    else $error("input position counter outside the volume");

endmodule

// ----- hw/rtl/bmm_ram.sv -----
// ----------------------------------------------------------------------------
// bmm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/bmm_pass.sv -----
// ----------------------------------------------------------------------------
// bmm_pass
// One axis of the separable max/min filter. Each token reads the two
// previous values on its axis from RAM, writes back the shifted pair and
// emits zero, one or two filtered tokens for the window targets.
// ----------------------------------------------------------------------------
module bmm_pass
  import bmm_pkg::*;
#(
  parameter int VAL_W  = DEF_SAMPLE_BITS,
  parameter int IDX_W  = 6,
  parameter int ADDR_W = 8,
  parameter int TAG_W  = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    mode,
  input  logic [IDX_W:0]          axis_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_val,
  input  logic [IDX_W-1:0]        in_idx,
  input  logic [ADDR_W-1:0]       in_addr,
  input  logic [TAG_W-1:0]        in_tag,
  input  bmm_ctl_t                in_ctl,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_val,
  output logic [IDX_W-1:0]        out_idx,
  output logic                    out_slot,
  output logic [TAG_W-1:0]        out_tag,
  output bmm_ctl_t                out_ctl
);

  function automatic logic signed [VAL_W-1:0] pick(input logic m,
                                                   input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    if (m == MODE_MIN) begin
      pick = (a < b) ? a : b;
    end else begin
      pick = (a > b) ? a : b;
    end
  endfunction

  // token register
  logic                    tok_v_r;
  logic signed [VAL_W-1:0] tok_val_r;
  logic [IDX_W-1:0]        tok_idx_r;
  logic [ADDR_W-1:0]       tok_addr_r;
  logic [TAG_W-1:0]        tok_tag_r;
  bmm_ctl_t                tok_ctl_r;

  // bypass for a read that hit the entry written on the same edge
  logic                    fwd_hit_r;
  logic [2*VAL_W-1:0]      fwd_data_r;

  // two-entry emit buffer: head drives the output
  logic [1:0]              cnt_r;
  logic signed [VAL_W-1:0] h_val_r;
  logic [IDX_W-1:0]        h_idx_r;
  logic                    h_slot_r;
  logic [TAG_W-1:0]        h_tag_r;
  bmm_ctl_t                h_ctl_r;
  logic signed [VAL_W-1:0] s_val_r;
  logic [IDX_W-1:0]        s_idx_r;
  bmm_ctl_t                s_ctl_r;

  logic                    accept;
  logic                    fire;
  logic                    take;
  logic [2*VAL_W-1:0]      ram_rdata;
  logic [2*VAL_W-1:0]      hist;
  logic [2*VAL_W-1:0]      wdata;
  logic signed [VAL_W-1:0] prev1;
  logic signed [VAL_W-1:0] prev2;
  logic signed [VAL_W-1:0] win;
  logic                    is_first;
  logic                    is_last;
  logic                    is_inner;
  logic [1:0]              k;
  logic signed [VAL_W-1:0] t0_val;
  logic [IDX_W-1:0]        t0_idx;
  bmm_ctl_t                t0_ctl;
  bmm_ctl_t                t1_ctl;

  assign take     = out_valid && out_ready;
  assign fire     = tok_v_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready));
  assign in_ready = !tok_v_r || fire;
  assign accept   = in_valid && in_ready;

  assign hist  = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign prev1 = $signed(hist[VAL_W-1:0]);
  assign prev2 = $signed(hist[2*VAL_W-1:VAL_W]);
  assign win   = pick(mode, pick(mode, tok_val_r, prev1), prev2);
  assign wdata = {prev1, tok_val_r};

  assign is_first = (tok_idx_r == '0);
  assign is_last  = ({1'b0, tok_idx_r} == (axis_n - 1'b1));
  assign is_inner = (tok_idx_r > IDX_W'(1)) && !is_last;

  always_comb begin
    k      = 2'd0;
    t0_val = win;
    t0_idx = tok_idx_r - 1'b1;
    if (is_first) begin
      k      = 2'd1;
      t0_val = tok_val_r;
      t0_idx = tok_idx_r;
    end else if (is_last) begin
      k = 2'd2;
    end else if (is_inner) begin
      k = 2'd1;
    end
    // the first target never sits on the far border of the axis
    t0_ctl.last   = tok_ctl_r.last && (k == 2'd1);
    t0_ctl.at_end = 1'b0;
    t1_ctl.last   = tok_ctl_r.last;
    t1_ctl.at_end = tok_ctl_r.at_end;
  end

  bmm_ram #(
    .WIDTH (2*VAL_W),
    .DEPTH (2**ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (tok_addr_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r   <= 1'b0;
      fwd_hit_r <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (accept) begin
        tok_v_r   <= 1'b1;
        fwd_hit_r <= fire && (in_addr == tok_addr_r);
      end else if (fire) begin
        tok_v_r <= 1'b0;
      end
      if (fire) begin
        cnt_r <= k;
      end else if (take) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_val_r  <= in_val;
      tok_idx_r  <= in_idx;
      tok_addr_r <= in_addr;
      tok_tag_r  <= in_tag;
      tok_ctl_r  <= in_ctl;
    end
    if (accept && fire) begin
      fwd_data_r <= wdata;
    end
    if (fire) begin
      h_val_r  <= t0_val;
      h_idx_r  <= t0_idx;
      h_slot_r <= 1'b0;
      h_tag_r  <= tok_tag_r;
      h_ctl_r  <= t0_ctl;
      s_val_r  <= tok_val_r;
      s_idx_r  <= tok_idx_r;
      s_ctl_r  <= t1_ctl;
    end else if (take && (cnt_r == 2'd2)) begin
      h_val_r  <= s_val_r;
      h_idx_r  <= s_idx_r;
      h_slot_r <= 1'b1;
      h_ctl_r  <= s_ctl_r;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_val   = h_val_r;
  assign out_idx   = h_idx_r;
  assign out_slot  = h_slot_r;
  assign out_tag   = h_tag_r;
  assign out_ctl   = h_ctl_r;

endmodule
